// ===== design/scm_pkg.sv =====
// Shared constants and types for the substring contains matcher.
package scm_pkg;

	localparam int BYTE_W       = 8;
	localparam int CFG_W        = 64;
	localparam int LEN_W        = 5;
	localparam int NEEDLE_BYTES = 16;
	localparam int NEEDLE_IDX_W = $clog2(NEEDLE_BYTES);
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_NEEDLE_DEF = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd2;

	// Per-cell compare setup: whether the cell takes part, and the needle byte it expects.
	typedef struct packed {
		logic              used;
		logic [BYTE_W-1:0] target;
	} cell_ctl_t;

endpackage

// ===== design/scm_if.sv =====
// Stream interfaces for haystack bytes and match results.
interface scm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] haystack_byte;
	logic       final_byte;

	modport source (output valid, output haystack_byte, output final_byte, input ready);
	modport sink (input valid, input haystack_byte, input final_byte, output ready);
endinterface

interface scm_out_if;
	logic valid;
	logic ready;
	logic match_here;
	logic found_so_far;
	logic answer_final;

	modport source (output valid, output match_here, output found_so_far,
		output answer_final, input ready);
	modport sink (input valid, input match_here, input found_so_far,
		input answer_final, output ready);
endinterface

// ===== design/scm_needle_cfg.sv =====
// Needle registers and per-cell compare setup.
module scm_needle_cfg #(
	parameter int MAX_NEEDLE = scm_pkg::MAX_NEEDLE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [scm_pkg::CFG_IDX_W-1:0]       index,
	input  logic [scm_pkg::CFG_W-1:0]           data,
	output scm_pkg::cell_ctl_t                  ctl [MAX_NEEDLE]
);

	logic [scm_pkg::CFG_W-1:0]   needle_low_q;
	logic [scm_pkg::CFG_W-1:0]   needle_high_q;
	logic [scm_pkg::LEN_W-1:0]   len_q;
	logic [scm_pkg::LEN_W-1:0]   len_used;
	logic [2*scm_pkg::CFG_W-1:0] needle_all;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q  <= '0;
			needle_high_q <= '0;
			len_q         <= scm_pkg::LEN_W'(1);
		end else if (we) begin
			case (index)
				scm_pkg::REG_NEEDLE_LOW:  needle_low_q  <= data;
				scm_pkg::REG_NEEDLE_HIGH: needle_high_q <= data;
				scm_pkg::REG_NEEDLE_LEN:  len_q         <= data[scm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero length counts as one, anything past the window saturates.
	always_comb begin
		if (len_q == '0)
			len_used = scm_pkg::LEN_W'(1);
		else if (len_q > scm_pkg::LEN_W'(MAX_NEEDLE))
			len_used = scm_pkg::LEN_W'(MAX_NEEDLE);
		else
			len_used = len_q;
	end

	assign needle_all = {needle_high_q, needle_low_q};

	// Window slot i must hold needle byte len-1-i.
	always_comb begin
		for (int i = 0; i < MAX_NEEDLE; i++) begin
			logic [scm_pkg::LEN_W-1:0]        pos;
			logic [scm_pkg::NEEDLE_IDX_W-1:0] sel;
			pos = len_used - scm_pkg::LEN_W'(i) - scm_pkg::LEN_W'(1);
			sel = pos[scm_pkg::NEEDLE_IDX_W-1:0];
			ctl[i].used   = scm_pkg::LEN_W'(i) < len_used;
			ctl[i].target = needle_all[sel*scm_pkg::BYTE_W +: scm_pkg::BYTE_W];
		end
	end

endmodule

// ===== design/scm_cell.sv =====
// One window slot: holds a byte, passes it on, checks the incoming byte.
module scm_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       clear,
	input  logic [scm_pkg::BYTE_W-1:0] in_byte,
	input  logic                       in_valid,
	input  scm_pkg::cell_ctl_t         ctl,
	output logic [scm_pkg::BYTE_W-1:0] out_byte,
	output logic                       out_valid,
	output logic                       ok
);

	logic [scm_pkg::BYTE_W-1:0] byte_q;
	logic                       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid & ~clear;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= in_byte;
		end
	end

	// Compare what this slot holds once the window has shifted.
	assign ok        = ~ctl.used | (in_valid & (in_byte == ctl.target));
	assign out_byte  = byte_q;
	assign out_valid = valid_q;

endmodule

// ===== design/substring_contains_matcher.sv =====
// Top level of the streaming substring contains matcher.
// The block searches a byte stream for a needle of 1 to MAX_NEEDLE bytes set
// through the configuration port (needle_bytes_low, needle_bytes_high,
// needle_length; a length of zero acts as one, a length past MAX_NEEDLE acts
// as MAX_NEEDLE). Each haystack beat yields one result beat: match_here says
// the needle ends at this byte, found_so_far is the sticky flag for the
// current haystack, and answer_final marks the result of the byte flagged
// final_byte, whose found_so_far is the answer. After the final byte the
// window and flag clear for the next string. The window is a row of
// MAX_NEEDLE cells that shift on each beat and all compare in parallel, and
// a single output register decouples the result side, so input is taken, at
// one byte per cycle, whenever that register is empty or drained.
// Write configuration only while no haystack is in flight.
module substring_contains_matcher #(
	parameter int MAX_NEEDLE = scm_pkg::MAX_NEEDLE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [scm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scm_pkg::CFG_W-1:0]     cfg_data,
	scm_in_if.sink                        haystack,
	scm_out_if.source                     result
);

	scm_pkg::cell_ctl_t         ctl [MAX_NEEDLE];
	logic [scm_pkg::BYTE_W-1:0] chain_byte [MAX_NEEDLE];
	logic                       chain_valid [MAX_NEEDLE];
	logic [MAX_NEEDLE-1:0]      cell_ok;

	logic advance;
	logic hit;
	logic found_next;
	logic found_flag_q;
	logic out_valid_q;
	logic match_q;
	logic found_out_q;
	logic final_q;

	// Take a beat whenever the result register is free or being drained.
	assign haystack.ready = ~out_valid_q | result.ready;
	assign advance        = haystack.valid & haystack.ready;

	scm_needle_cfg #(
		.MAX_NEEDLE(MAX_NEEDLE)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.ctl    (ctl)
	);

	// Cell 0 takes the new byte; each later cell takes its neighbor's content.
	for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
		if (i == 0) begin : g_head
			scm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.advance   (advance),
				.clear     (haystack.final_byte),
				.in_byte   (haystack.haystack_byte),
				.in_valid  (1'b1),
				.ctl       (ctl[i]),
				.out_byte  (chain_byte[i]),
				.out_valid (chain_valid[i]),
				.ok        (cell_ok[i])
			);
		end else begin : g_body
			scm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.advance   (advance),
				.clear     (haystack.final_byte),
				.in_byte   (chain_byte[i-1]),
				.in_valid  (chain_valid[i-1]),
				.ctl       (ctl[i]),
				.out_byte  (chain_byte[i]),
				.out_valid (chain_valid[i]),
				.ok        (cell_ok[i])
			);
		end
	end

	// A match needs every used slot filled from this haystack and equal.
	assign hit        = &cell_ok;
	assign found_next = found_flag_q | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_flag_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				// Drop the sticky flag once the haystack closes.
				found_flag_q <= found_next & ~haystack.final_byte;
				out_valid_q  <= 1'b1;
			end else if (result.ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// Hold the result payload until the next beat replaces it.
	always_ff @(posedge clk) begin
		if (advance) begin
			match_q     <= hit;
			found_out_q <= found_next;
			final_q     <= haystack.final_byte;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.match_here   = match_q;
	assign result.found_so_far = found_out_q;
	assign result.answer_final = final_q;

endmodule
